// ===== hw/rtl/gshare_branch_predictor_defines.svh =====
// Assertion macros shared by the predictor RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef GSHARE_BRANCH_PREDICTOR_DEFINES_SVH
`define GSHARE_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle property.
`define GBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define GBP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gbp_pkg.sv =====
package gbp_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned HB_W   = 4;

  typedef logic [1:0]        ctr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [HB_W-1:0]   hist_bits_t;

  localparam ctr_t       CTR_MIN        = 2'd0;
  localparam ctr_t       CTR_WEAK_TAKEN = 2'd2;
  localparam ctr_t       CTR_MAX        = 2'd3;
  localparam hist_bits_t HIST_BITS_RST  = 4'd8;

  // 2-bit saturating counter step toward the actual outcome
  function automatic ctr_t ctr_next(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? c : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? c : c - 2'd1;
    end
    return r;
  endfunction

  function automatic cnt_t cnt_inc(input cnt_t c, input logic en);
    cnt_t r;
    r = (en && (c != '1)) ? c + cnt_t'(1) : c;
    return r;
  endfunction

endpackage

// ===== hw/rtl/gbp_if.sv =====
interface gbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [gbp_pkg::ADDR_W-1:0]  branch_address;
  logic                        taken;

  modport source (output valid, output branch_address, output taken, input ready);
  modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface gbp_out_if;
  logic                 valid;
  logic                 ready;
  logic                 predicted_taken;
  logic                 mispredicted;
  gbp_pkg::cnt_t        branch_count;
  gbp_pkg::cnt_t        mispredict_count;

  modport source (output valid, output predicted_taken, output mispredicted,
                  output branch_count, output mispredict_count, input ready);
  modport sink   (input valid, input predicted_taken, input mispredicted,
                  input branch_count, input mispredict_count, output ready);
endinterface

// ===== hw/rtl/gshare_branch_predictor.sv =====
// Gshare predictor fed with resolved branches.
// br_i (valid/ready) carries one branch per transaction: address and actual
// direction. res_o (valid/ready) returns one result per branch, in order: the
// prediction read before the update, a mispredict flag, and saturating
// branch and mispredict counts that include this branch.
// Throughput: one branch per cycle, outside the reset sweep and while res_o is
// not stalled. The counter table is a single RAM with one write and one read
// port; the read is issued on acceptance and the updated counter is written
// back as the branch leaves the read stage, so back-to-back branches to the
// same entry take the freshest value from a write-back bypass.
// Each branch goes through the read stage and then the output register.
// Reset clears history and counts, loads history_bits with 8, then sweeps
// the table to weakly taken, one entry per cycle over all 2**IndexBits entries
// (1024 by default) with br_i.ready low. cfg_we_i is taken at any time.
// If res_o stalls, one result waits in the output register and one branch in
// the read stage; br_i.ready drops only in the sweep or when both are full.
`include "gshare_branch_predictor_defines.svh"

module gshare_branch_predictor #(
  parameter int unsigned IndexBits = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  gbp_pkg::hist_bits_t cfg_wdata_i,
  gbp_in_if.sink              br_i,
  gbp_out_if.source           res_o
);

  localparam int unsigned Depth = 1 << IndexBits;

  gbp_pkg::hist_bits_t  hist_bits_q;
  logic                 clearing_q;
  logic [IndexBits-1:0] clr_addr_q;

  logic                 s1_valid_q;
  logic [IndexBits-1:0] s1_idx_q;
  logic                 s1_taken_q;

  logic                 wb_valid_q;
  logic [IndexBits-1:0] wb_idx_q;
  gbp_pkg::ctr_t        wb_ctr_q;

  logic                 out_valid_q;
  logic                 out_pred_q;
  logic                 out_miss_q;
  gbp_pkg::cnt_t        br_cnt_q, br_cnt_d;
  gbp_pkg::cnt_t        miss_cnt_q, miss_cnt_d;

  logic                 accept;
  logic                 s1_adv;
  logic [IndexBits-1:0] rd_idx;
  gbp_pkg::ctr_t        ram_rdata;
  gbp_pkg::ctr_t        ctr_cur;
  gbp_pkg::ctr_t        ctr_new;
  logic                 pred;
  logic                 miss;
  logic                 ram_we;
  logic [IndexBits-1:0] ram_waddr;
  gbp_pkg::ctr_t        ram_wdata;

  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign br_i.ready  = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept      = br_i.valid && br_i.ready;

  gbp_hist #(
    .IndexBits (IndexBits)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hist_bits_i (hist_bits_q),
    .adv_i       (accept),
    .addr_i      (br_i.branch_address),
    .taken_i     (br_i.taken),
    .idx_o       (rd_idx)
  );

  assign ram_we    = clearing_q || s1_adv;
  assign ram_waddr = clearing_q ? clr_addr_q : s1_idx_q;
  assign ram_wdata = clearing_q ? gbp_pkg::CTR_WEAK_TAKEN : ctr_new;

  gbp_ram #(
    .Width ($bits(gbp_pkg::ctr_t)),
    .Depth (Depth)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // last write is always the newest value of its entry
  assign ctr_cur = (wb_valid_q && (wb_idx_q == s1_idx_q)) ? wb_ctr_q : ram_rdata;
  assign ctr_new = gbp_pkg::ctr_next(ctr_cur, s1_taken_q);
  assign pred    = ctr_cur[1];
  assign miss    = pred ^ s1_taken_q;

  assign br_cnt_d   = gbp_pkg::cnt_inc(br_cnt_q, 1'b1);
  assign miss_cnt_d = gbp_pkg::cnt_inc(miss_cnt_q, miss);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_bits_q <= gbp_pkg::HIST_BITS_RST;
    end else if (cfg_we_i) begin
      hist_bits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + IndexBits'(1);
      if (clr_addr_q == {IndexBits{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= rd_idx;
      s1_taken_q <= br_i.taken;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (s1_adv) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wb_idx_q <= s1_idx_q;
      wb_ctr_q <= ctr_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      br_cnt_q    <= '0;
      miss_cnt_q  <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        br_cnt_q    <= br_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pred_q <= pred;
      out_miss_q <= miss;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.predicted_taken  = out_pred_q;
  assign res_o.mispredicted     = out_miss_q;
  assign res_o.branch_count     = br_cnt_q;
  assign res_o.mispredict_count = miss_cnt_q;

  `GBP_ASSERT(a_no_accept_clearing, !(clearing_q && br_i.ready), "branch during sweep")
  `GBP_ASSERT(a_empty_clearing, !(clearing_q && (s1_valid_q || out_valid_q)), "busy during sweep")
  `GBP_ASSERT(a_miss_le_branches, miss_cnt_q <= br_cnt_q, "mispredict count above branch count")
  `GBP_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_idx_q), "stage lost")

endmodule

// ===== hw/rtl/gbp_ram.sv =====
module gbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read and a write to the same address return the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gbp_hist.sv =====
module gbp_hist #(
  parameter int unsigned IndexBits = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbp_pkg::hist_bits_t           hist_bits_i,
  input  logic                          adv_i,
  input  logic [gbp_pkg::ADDR_W-1:0]    addr_i,
  input  logic                          taken_i,
  output logic [IndexBits-1:0]          idx_o
);

  localparam int unsigned WW = $clog2(IndexBits + 1);

  logic [IndexBits-1:0] hist_q, hist_d;
  logic [IndexBits-1:0] hmask;
  logic [IndexBits-1:0] hist;
  logic [31:0]          hb_ext;
  logic [WW-1:0]        w;
  logic [WW-1:0]        shamt;

  // effective history width, clamped to 1..IndexBits
  always_comb begin
    hb_ext = 32'(hist_bits_i);
    if (hb_ext == 32'd0) begin
      w = WW'(1);
    end else if (hb_ext > 32'(IndexBits)) begin
      w = WW'(IndexBits);
    end else begin
      w = WW'(hb_ext);
    end
  end

  assign hmask = ~({IndexBits{1'b1}} << w);
  assign hist  = hist_q & hmask;
  assign shamt = WW'(IndexBits) - w;
  assign idx_o = (hist << shamt) ^ addr_i[IndexBits+1:2];

  assign hist_d = (hist >> 1) | ({{(IndexBits-1){1'b0}}, taken_i} << (w - WW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (adv_i) begin
      hist_q <= hist_d;
    end
  end

endmodule
